### src/hsmc_pkg.sv
// Package for the hybrid sliding-mode control core.
// Holds register indexes, reset values, fixed-point constants and the
// elaboration-time builder for the tanh table; no dependencies.
`default_nettype none

package hsmc_pkg;

	localparam int TANH_TABLE_DEPTH = 256;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_POS_SURFACE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ANGLE_SURFACE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_POS_SMOOTH    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ANGLE_SMOOTH  = 8'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_POS          = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_ANGLE        = 8'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN            = 8'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX            = 8'd7;

	localparam logic signed [23:0] OUT_MIN_RST = -24'sd65280;
	localparam logic signed [23:0] OUT_MAX_RST = 24'sd65280;

	localparam logic signed [15:0] TANH_ONE = 16'sd16384;

	localparam longint Q30_ONE    = 64'sd1 <<< 30;
	localparam longint TANH_ONE_L = 64'sd16384;

	// quotient truncated toward zero, by shift and subtract
	function automatic longint div_trunc(input longint n, input longint d);
		longint an;
		longint ad;
		longint q;
		longint r;
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		q  = 64'sd0;
		r  = 64'sd0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((an >>> b) & 64'sd1);
			q = q <<< 1;
			if (r >= ad) begin
				r = r - ad;
				q = q | 64'sd1;
			end
		end
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	// tanh(y / 2^31) in Q1.14 with y in Q2.31 units of the table argument
	function automatic logic signed [15:0] tanh_entry(input longint y);
		longint t;
		longint term;
		longint e;
		longint num;
		longint den;
		t    = y >>> 6;
		term = Q30_ONE;
		e    = Q30_ONE;
		for (int k = 0; k < 10; k++) begin
			term = div_trunc(-(term * t), longint'(k + 1) <<< 30);
			e    = e + term;
		end
		for (int k = 0; k < 6; k++) begin
			e = (e * e) >>> 30;
		end
		num = (Q30_ONE - e) * (64'sd2 * TANH_ONE_L) + (Q30_ONE + e);
		den = 64'sd2 * (Q30_ONE + e);
		return 16'(div_trunc(num, den));
	endfunction

endpackage

`default_nettype wire

### src/hybrid_sliding_mode_control_core.sv
// Hybrid sliding-mode control core: two sliding surfaces, tanh smoothing
// and a clamped Q16.8 drive, as one 14-stage pipeline.
// Depends on hsmc_pkg.
`default_nettype none

// One state vector enters per clock unless the drive channel stalls, and its
// drive leaves from the last of a fixed pipeline of 14 registers. A stall on the
// drive channel freezes every stage at once and raises item_stall in the same
// cycle. The tanh table (TANH_TABLE_DEPTH + 1 entries, Q1.14) is built at
// elaboration and read through registered ports, so no table load or clearing
// pass follows reset. The configuration port is always ready; write it only
// while no item is in flight.
module hybrid_sliding_mode_control_core #(
	parameter int TANH_TABLE_DEPTH = hsmc_pkg::TANH_TABLE_DEPTH
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              item_valid,
	output logic                             item_stall,
	input  wire  signed [15:0]               pos,
	input  wire  signed [15:0]               pos_rate,
	input  wire  signed [15:0]               angle,
	input  wire  signed [15:0]               angle_rate,
	output logic                             drive_valid,
	input  wire                              drive_stall,
	output logic signed [23:0]               drive,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [hsmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [hsmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDXW = $clog2(TANH_TABLE_DEPTH);
	localparam int RW   = $clog2(TANH_TABLE_DEPTH + 1);
	localparam int PW   = 22 + IDXW;
	localparam int NS   = 14;

	logic signed [15:0] slope_q    [2];
	logic signed [15:0] gain_lin_q [2];
	logic signed [15:0] gain_sm_q  [2];
	logic signed [23:0] out_min_q;
	logic signed [23:0] out_max_q;

	logic signed [15:0] tanh_rom [TANH_TABLE_DEPTH + 1];

	for (genvar g = 0; g <= TANH_TABLE_DEPTH; g++) begin : g_rom
		localparam longint Y = (longint'(g) <<< 33) / TANH_TABLE_DEPTH;
		localparam logic signed [15:0] ENTRY = hsmc_pkg::tanh_entry(Y);
		assign tanh_rom[g] = ENTRY;
	end

	logic [NS-1:0] v_q;
	logic          adv;

	logic signed [15:0] x_in [2];
	logic signed [15:0] r_in [2];

	logic signed [31:0]   prod_s1   [2];
	logic signed [15:0]   rate_s1   [2];
	logic signed [32:0]   surf_s2   [2];
	logic signed [32:0]   surf_s3   [2];
	logic        [32:0]   mag_s3    [2];
	logic                 neg_s3    [2];
	logic        [IDXW-1:0] idx_s4  [2];
	logic        [21:0]   frac_s4   [2];
	logic                 neg_s4    [2];
	logic                 sat_s4    [2];
	logic signed [48:0]   lin_s4    [2];
	logic signed [15:0]   lo_s5     [2];
	logic signed [15:0]   hi_s5     [2];
	logic        [21:0]   frac_s5   [2];
	logic                 neg_s5    [2];
	logic                 sat_s5    [2];
	logic signed [48:0]   lin_s5    [2];
	logic signed [16:0]   diff_s6   [2];
	logic signed [15:0]   lo_s6     [2];
	logic        [21:0]   frac_s6   [2];
	logic                 neg_s6    [2];
	logic                 sat_s6    [2];
	logic signed [48:0]   lin_s6    [2];
	logic signed [39:0]   iprod_s7  [2];
	logic signed [15:0]   lo_s7     [2];
	logic                 neg_s7    [2];
	logic                 sat_s7    [2];
	logic signed [48:0]   lin_s7    [2];
	logic signed [15:0]   tmag_s8   [2];
	logic                 neg_s8    [2];
	logic signed [48:0]   lin_s8    [2];
	logic signed [15:0]   tanh_s9   [2];
	logic signed [48:0]   lin_s9    [2];
	logic signed [31:0]   smooth_s10 [2];
	logic signed [48:0]   lin_s10   [2];
	logic signed [49:0]   term_s11  [2];
	logic signed [50:0]   acc_s12;
	logic signed [31:0]   u_s13;
	logic signed [23:0]   drive_s14;

	logic signed [39:0]   iround    [2];
	logic        [PW-1:0] ptab      [2];
	logic signed [51:0]   nacc;
	logic signed [31:0]   lim_min;
	logic signed [31:0]   lim_max;

	assign x_in[0] = pos;
	assign x_in[1] = angle;
	assign r_in[0] = pos_rate;
	assign r_in[1] = angle_rate;

	assign adv        = !(v_q[NS-1] && drive_stall);
	assign item_stall = v_q[NS-1] && drive_stall;
	assign cfg_ready  = 1'b1;

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			iround[j] = iprod_s7[j] + 40'sd2097152;
			ptab[j]   = PW'(mag_s3[j][21:0]) * PW'(TANH_TABLE_DEPTH);
		end
		nacc    = 52'sd524288 - {acc_s12[50], acc_s12};
		lim_min = {{8{out_min_q[23]}}, out_min_q};
		lim_max = {{8{out_max_q[23]}}, out_max_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 2; j++) begin
				slope_q[j]    <= '0;
				gain_lin_q[j] <= '0;
				gain_sm_q[j]  <= '0;
			end
			out_min_q <= hsmc_pkg::OUT_MIN_RST;
			out_max_q <= hsmc_pkg::OUT_MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				hsmc_pkg::CFG_GAIN_POS_SURFACE:   gain_lin_q[0] <= cfg_data[15:0];
				hsmc_pkg::CFG_GAIN_ANGLE_SURFACE: gain_lin_q[1] <= cfg_data[15:0];
				hsmc_pkg::CFG_GAIN_POS_SMOOTH:    gain_sm_q[0]  <= cfg_data[15:0];
				hsmc_pkg::CFG_GAIN_ANGLE_SMOOTH:  gain_sm_q[1]  <= cfg_data[15:0];
				hsmc_pkg::CFG_SLOPE_POS:          slope_q[0]    <= cfg_data[15:0];
				hsmc_pkg::CFG_SLOPE_ANGLE:        slope_q[1]    <= cfg_data[15:0];
				hsmc_pkg::CFG_OUT_MIN:            out_min_q     <= cfg_data[23:0];
				hsmc_pkg::CFG_OUT_MAX:            out_max_q     <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NS-2:0], item_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 2; j++) begin
				prod_s1[j] <= slope_q[j] * x_in[j];
				rate_s1[j] <= r_in[j];

				surf_s2[j] <= {{9{rate_s1[j][15]}}, rate_s1[j], 8'd0}
					+ {prod_s1[j][31], prod_s1[j]};

				surf_s3[j] <= surf_s2[j];
				neg_s3[j]  <= surf_s2[j][32];
				mag_s3[j]  <= surf_s2[j][32] ? 33'(-surf_s2[j]) : surf_s2[j];

				idx_s4[j]  <= ptab[j][PW-1:22];
				frac_s4[j] <= ptab[j][21:0];
				neg_s4[j]  <= neg_s3[j];
				sat_s4[j]  <= |mag_s3[j][32:22];
				lin_s4[j]  <= gain_lin_q[j] * surf_s3[j];

				lo_s5[j]   <= tanh_rom[RW'(idx_s4[j])];
				hi_s5[j]   <= tanh_rom[RW'(idx_s4[j]) + RW'(1)];
				frac_s5[j] <= frac_s4[j];
				neg_s5[j]  <= neg_s4[j];
				sat_s5[j]  <= sat_s4[j];
				lin_s5[j]  <= lin_s4[j];

				diff_s6[j] <= {hi_s5[j][15], hi_s5[j]} - {lo_s5[j][15], lo_s5[j]};
				lo_s6[j]   <= lo_s5[j];
				frac_s6[j] <= frac_s5[j];
				neg_s6[j]  <= neg_s5[j];
				sat_s6[j]  <= sat_s5[j];
				lin_s6[j]  <= lin_s5[j];

				iprod_s7[j] <= diff_s6[j] * $signed({1'b0, frac_s6[j]});
				lo_s7[j]    <= lo_s6[j];
				neg_s7[j]   <= neg_s6[j];
				sat_s7[j]   <= sat_s6[j];
				lin_s7[j]   <= lin_s6[j];

				tmag_s8[j] <= sat_s7[j] ? hsmc_pkg::TANH_ONE
					: lo_s7[j] + iround[j][37:22];
				neg_s8[j]  <= neg_s7[j];
				lin_s8[j]  <= lin_s7[j];

				tanh_s9[j] <= neg_s8[j] ? -tmag_s8[j] : tmag_s8[j];
				lin_s9[j]  <= lin_s8[j];

				smooth_s10[j] <= gain_sm_q[j] * tanh_s9[j];
				lin_s10[j]    <= lin_s9[j];

				term_s11[j] <= {lin_s10[j][48], lin_s10[j]}
					+ {{12{smooth_s10[j][31]}}, smooth_s10[j], 6'd0};
			end

			acc_s12 <= {term_s11[0][49], term_s11[0]} + {term_s11[1][49], term_s11[1]};

			u_s13 <= nacc[51:20];

			if (u_s13 > lim_max) begin
				drive_s14 <= out_max_q;
			end else if (u_s13 < lim_min) begin
				drive_s14 <= out_min_q;
			end else begin
				drive_s14 <= u_s13[23:0];
			end
		end
	end

	assign drive_valid = v_q[NS-1];
	assign drive       = drive_s14;

endmodule

`default_nettype wire

### src/hsmc_checker.sv
// Port-level checker for the hybrid sliding-mode control core, bound to
// the top level below. Depends only on the top level's ports.
`default_nettype none

module hsmc_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               item_stall,
	input wire               drive_valid,
	input wire               drive_stall,
	input wire signed [23:0] drive,
	input wire               cfg_valid,
	input wire               cfg_ready
);

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !drive_valid)
		else $error("drive_valid high during reset");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> drive_valid && drive_stall)
		else $error("item stalled without a stalled drive item");

	a_stall_reach: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall |-> item_stall)
		else $error("drive stalled but items still accepted");

	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall |=> drive_valid && $stable(drive))
		else $error("stalled drive item changed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind hybrid_sliding_mode_control_core hsmc_checker u_hsmc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_stall  (item_stall),
	.drive_valid (drive_valid),
	.drive_stall (drive_stall),
	.drive       (drive),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);

`default_nettype wire
